// File: hdl/dtp_pkg.sv
`timescale 1ns / 1ps

package dtp_pkg;

    // Default curve exponents
    localparam int TURN_EXP_DEF  = 7;
    localparam int DRIVE_EXP_DEF = 3;

    // Shared divider and multiplier widths
    localparam int DIV_NUM_W = 24;
    localparam int DIV_DEN_W = 8;
    localparam int MUL_W     = 17;

    localparam int CORDIC_STEPS = 18;

    // Power and angle constants (1/16 units)
    localparam logic signed [12:0] PWR_LIMIT = 13'sd2032;
    localparam logic [16:0]        CURVE_CAP = 17'd4096;
    localparam logic signed [17:0] FULL_TURN = 18'sd5760;
    localparam logic signed [17:0] HALF_TURN = 18'sd2880;

    // Angles in 1/65536 degree
    localparam logic [23:0] DEG_45  = 24'd2949120;
    localparam logic [23:0] DEG_90  = 24'd5898240;
    localparam logic [23:0] DEG_180 = 24'd11796480;

    // Input command codes
    localparam logic CMD_TICK = 1'b0;
    localparam logic CMD_LOAD = 1'b1;

    // Configuration register indexes
    typedef enum logic [2:0] {
        REG_TURN_THR   = 3'd0,
        REG_TURN_SLOW  = 3'd1,
        REG_TURN_GAIN  = 3'd2,
        REG_TURN_MIN   = 3'd3,
        REG_DRIVE_THR  = 3'd4,
        REG_DRIVE_SLOW = 3'd5,
        REG_DRIVE_GAIN = 3'd6,
        REG_DRIVE_MIN  = 3'd7
    } t_reg_idx;

    // Reported phase
    typedef enum logic [1:0] {
        PH_AIM   = 2'd0,
        PH_DRIVE = 2'd1,
        PH_FINAL = 2'd2
    } t_phase;

    // atan(2^-i) in 1/65536 degree
    function automatic logic [21:0] atan_step(input logic [4:0] i);
        logic [21:0] v;
        begin
            case (i)
                5'd0:    v = 22'd2949120;
                5'd1:    v = 22'd1740967;
                5'd2:    v = 22'd919879;
                5'd3:    v = 22'd466945;
                5'd4:    v = 22'd234379;
                5'd5:    v = 22'd117304;
                5'd6:    v = 22'd58666;
                5'd7:    v = 22'd29335;
                5'd8:    v = 22'd14668;
                5'd9:    v = 22'd7334;
                5'd10:   v = 22'd3667;
                5'd11:   v = 22'd1833;
                5'd12:   v = 22'd917;
                5'd13:   v = 22'd458;
                5'd14:   v = 22'd229;
                5'd15:   v = 22'd115;
                5'd16:   v = 22'd57;
                5'd17:   v = 22'd29;
                default: v = 22'd0;
            endcase
            return v;
        end
    endfunction

endpackage

// File: hdl/drive_to_point_controller.sv
`timescale 1ns / 1ps

// Channel   Direction  Handshake                   Payload
// input     in         i_in_valid / o_in_stall     command, set_value, target, heading, pose
// output    out        o_out_valid / i_out_stall   left/right power, arrived, phase
// config    in         i_cfg_we                    i_cfg_index, i_cfg_data
//
// A control tick runs the bearing CORDIC in 18 steps, wraps the heading error, takes a
// 17-step square root, and runs each power curve as a 24-step divide plus E-1 multiply
// steps and the minimum and gain steps; a second divide follows when E is 1. A load
// command is handled in the idle state.
// Synchronous active-low reset clears the phase flags and restores register defaults.
// Input is stalled while a tick is in work; a finished result waits in the output
// register, and the next tick is taken while it waits.
module drive_to_point_controller #(
    parameter int TURN_EXPONENT  = dtp_pkg::TURN_EXP_DEF,
    parameter int DRIVE_EXPONENT = dtp_pkg::DRIVE_EXP_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // input channel
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic               i_command,
    input  logic               i_set_value,
    input  logic signed [11:0] i_target_x,
    input  logic signed [11:0] i_target_y,
    input  logic signed [9:0]  i_final_heading,
    input  logic signed [15:0] i_pose_x,
    input  logic signed [15:0] i_pose_y,
    input  logic signed [15:0] i_pose_angle,
    // output channel
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic signed [8:0]  o_left_power,
    output logic signed [8:0]  o_right_power,
    output logic               o_arrived,
    output logic [1:0]         o_phase,
    // configuration
    input  logic               i_cfg_we,
    input  logic [2:0]         i_cfg_index,
    input  logic [7:0]         i_cfg_data
);
    import dtp_pkg::*;

    localparam logic [2:0] TURN_E  = 3'(TURN_EXPONENT);
    localparam logic [2:0] DRIVE_E = 3'(DRIVE_EXPONENT);

    typedef enum logic [4:0] {
        S_IDLE, S_PREP, S_CORD, S_AIM, S_WRAP, S_FIN, S_SQ1, S_SQ2, S_SQ3, S_SQRT,
        S_CDIV, S_CDWT, S_CPOW, S_CMIN, S_CMST, S_CMWT, S_CGAIN, S_EMIT
    } t_state;

    // Truncate a 1/16 power toward zero to whole units
    function automatic logic signed [8:0] tz16(input logic signed [13:0] v);
        logic [13:0]       mag;
        logic signed [8:0] q;
        begin
            mag = v[13] ? 14'(-v) : 14'(v);
            q   = signed'(mag[12:4]);
            return v[13] ? -q : q;
        end
    endfunction

    // Configuration registers
    logic [5:0] r_turn_thr;
    logic [7:0] r_turn_slow;
    logic [7:0] r_turn_gain;
    logic [6:0] r_turn_min;
    logic [7:0] r_drive_thr;
    logic [7:0] r_drive_slow;
    logic [7:0] r_drive_gain;
    logic [6:0] r_drive_min;

    // Control state
    t_state r_state;
    logic   r_aim_done;
    logic   r_drive_done;
    logic   r_final;
    logic   r_cv;
    t_phase r_ph;
    logic [4:0] r_cnt;
    logic [2:0] r_k;

    // Datapath
    logic signed [17:0] r_dx;
    logic signed [17:0] r_dy;
    logic signed [9:0]  r_hd;
    logic signed [15:0] r_pa;
    logic [26:0]        r_cx;
    logic signed [26:0] r_cy;
    logic signed [24:0] r_cz;
    logic [23:0]        r_ang;
    logic signed [17:0] r_m;
    logic [33:0]        r_s;
    logic [33:0]        r_src;
    logic [17:0]        r_rem;
    logic [16:0]        r_root;
    logic signed [17:0] r_v;
    logic [16:0]        r_mag;
    logic [16:0]        r_p;
    logic [23:0]        r_num;
    logic signed [24:0] r_mterm;
    logic signed [12:0] r_pd;

    // Pending and output results
    logic signed [8:0] r_res_l;
    logic signed [8:0] r_res_r;
    logic              r_res_arr;
    t_phase            r_res_ph;
    logic              r_o_valid;
    logic signed [8:0] r_o_l;
    logic signed [8:0] r_o_r;
    logic              r_o_arr;
    logic [1:0]        r_o_ph;

    // Combinational helpers
    logic [16:0]        w_adx, w_ady, w_vabs, w_eabs;
    logic               w_aligned;
    logic [MUL_W-1:0]   w_ma, w_mb;
    logic [2*MUL_W-1:0] w_prod;
    logic [2:0]         w_e;
    logic               w_div_start, w_div_done;
    logic [DIV_NUM_W-1:0] w_div_num, w_div_quo;
    logic [DIV_DEN_W-1:0] w_div_den;
    logic [26:0]        w_cyabs, w_ys, w_xs;
    logic signed [24:0] w_atan, n_z;
    logic [23:0]        n_ang, w_a2;
    logic signed [8:0]  w_deg, w_aim;
    logic [19:0]        w_remsh;
    logic [18:0]        w_trial;
    logic               w_sq_ge;
    logic [16:0]        n_root;
    logic [29:0]        w_pn;
    logic               w_neg;
    logic signed [26:0] w_cterm, w_sum;
    logic signed [12:0] w_pw;
    logic signed [13:0] w_lsum, w_rsum;

    assign w_adx  = r_dx[17] ? 17'(-r_dx) : 17'(r_dx);
    assign w_ady  = r_dy[17] ? 17'(-r_dy) : 17'(r_dy);
    assign w_vabs = r_v[17] ? 17'(-r_v) : 17'(r_v);
    assign w_eabs = r_m[17] ? 17'(-r_m) : 17'(r_m);
    assign w_aligned = w_eabs <= {7'b0, r_turn_thr, 4'b0};
    assign w_e = r_cv ? DRIVE_E : TURN_E;

    // Shared multiplier, operands chosen by the sequencer
    always_comb begin
        case (r_state)
            S_SQ1:   begin w_ma = w_adx;                 w_mb = w_adx;  end
            S_SQ2:   begin w_ma = w_ady;                 w_mb = w_ady;  end
            S_SQ3:   begin w_ma = 17'(r_drive_thr);      w_mb = 17'(r_drive_thr); end
            S_CPOW:  begin w_ma = r_p;                   w_mb = r_mag;  end
            S_CMIN:  begin w_ma = r_cv ? 17'(r_drive_min) : 17'(r_turn_min);
                           w_mb = w_vabs; end
            S_CGAIN: begin w_ma = r_cv ? 17'(r_drive_gain) : 17'(r_turn_gain);
                           w_mb = r_p; end
            default: begin w_ma = '0;                    w_mb = '0;     end
        endcase
    end
    assign w_prod = w_ma * w_mb;

    // Shared divider
    assign w_div_start = (r_state == S_CDIV) || (r_state == S_CMST);
    assign w_div_num   = (r_state == S_CMST) ? r_num : DIV_NUM_W'(w_vabs);
    always_comb begin
        if (r_state == S_CMST) begin
            w_div_den = r_cv ? r_drive_thr : DIV_DEN_W'(r_turn_thr);
        end else begin
            w_div_den = r_cv ? r_drive_slow : r_turn_slow;
        end
    end

    dtp_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (w_div_num),
        .i_den   (w_div_den),
        .o_done  (w_div_done),
        .o_quo   (w_div_quo)
    );

    // CORDIC step
    assign w_cyabs = r_cy[26] ? 27'(-r_cy) : 27'(r_cy);
    assign w_ys    = w_cyabs >> r_cnt;
    assign w_xs    = r_cx >> r_cnt;
    assign w_atan  = signed'(25'(atan_step(r_cnt)));
    assign n_z     = (r_cy > 0) ? r_cz + w_atan : r_cz - w_atan;
    always_comb begin
        if (n_z < 0) begin
            n_ang = '0;
        end else if (n_z > signed'({1'b0, DEG_90})) begin
            n_ang = DEG_90;
        end else begin
            n_ang = n_z[23:0];
        end
    end

    // Quadrant fold and whole degrees
    assign w_a2  = r_dy[17] ? DEG_180 - r_ang : r_ang;
    assign w_deg = signed'({1'b0, w_a2[23:16]});
    assign w_aim = r_dx[17] ? -w_deg : w_deg;

    // Square root step, two radicand bits per cycle
    assign w_remsh = {r_rem, r_src[33:32]};
    assign w_trial = {r_root, 2'b01};
    assign w_sq_ge = w_remsh >= 20'(w_trial);
    assign n_root  = {r_root[15:0], w_sq_ge};

    // Power curve pieces
    assign w_pn    = w_prod[33:4];
    assign w_neg   = r_v[17] && (r_mag != '0) && w_e[0];
    assign w_cterm = w_neg ? -signed'(27'(w_prod[24:0])) : signed'(27'(w_prod[24:0]));
    assign w_sum   = w_cterm + 27'(r_mterm);
    always_comb begin
        if (w_sum > 27'(PWR_LIMIT)) begin
            w_pw = PWR_LIMIT;
        end else if (w_sum < -27'(PWR_LIMIT)) begin
            w_pw = -PWR_LIMIT;
        end else begin
            w_pw = 13'(w_sum);
        end
    end
    assign w_lsum = 14'(r_pd) + 14'(w_pw);
    assign w_rsum = 14'(r_pd) - 14'(w_pw);

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_turn_thr   <= 6'd2;
            r_turn_slow  <= 8'd75;
            r_turn_gain  <= 8'd90;
            r_turn_min   <= 7'd20;
            r_drive_thr  <= 8'd5;
            r_drive_slow <= 8'd15;
            r_drive_gain <= 8'd20;
            r_drive_min  <= 7'd20;
        end else if (i_cfg_we) begin
            case (t_reg_idx'(i_cfg_index))
                REG_TURN_THR:   r_turn_thr   <= i_cfg_data[5:0];
                REG_TURN_SLOW:  r_turn_slow  <= i_cfg_data;
                REG_TURN_GAIN:  r_turn_gain  <= i_cfg_data;
                REG_TURN_MIN:   r_turn_min   <= i_cfg_data[6:0];
                REG_DRIVE_THR:  r_drive_thr  <= i_cfg_data;
                REG_DRIVE_SLOW: r_drive_slow <= i_cfg_data;
                REG_DRIVE_GAIN: r_drive_gain <= i_cfg_data;
                REG_DRIVE_MIN:  r_drive_min  <= i_cfg_data[6:0];
                default: ;
            endcase
        end
    end

    // Sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_aim_done   <= 1'b0;
            r_drive_done <= 1'b0;
            r_o_valid    <= 1'b0;
            r_final      <= 1'b0;
            r_cv         <= 1'b0;
            r_ph         <= PH_AIM;
            r_cnt        <= '0;
            r_k          <= '0;
        end else begin
            // S_EMIT handles the output register itself
            if (r_o_valid && !i_out_stall && r_state != S_EMIT) begin
                r_o_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        if (i_command == CMD_LOAD) begin
                            r_aim_done   <= i_set_value;
                            r_drive_done <= i_set_value;
                        end else begin
                            r_dx    <= {{2{i_target_x[11]}}, i_target_x, 4'b0}
                                       - {{2{i_pose_x[15]}}, i_pose_x};
                            r_dy    <= {{2{i_target_y[11]}}, i_target_y, 4'b0}
                                       - {{2{i_pose_y[15]}}, i_pose_y};
                            r_hd    <= i_final_heading;
                            r_pa    <= i_pose_angle;
                            r_state <= S_PREP;
                        end
                    end
                end
                // exact cases, else set up the vectoring CORDIC
                S_PREP: begin
                    if (w_adx == '0) begin
                        r_ang   <= '0;
                        r_state <= S_AIM;
                    end else if (w_ady == '0) begin
                        r_ang   <= DEG_90;
                        r_state <= S_AIM;
                    end else if (w_adx == w_ady) begin
                        r_ang   <= DEG_45;
                        r_state <= S_AIM;
                    end else begin
                        r_cx    <= 27'({w_ady, 8'b0});
                        r_cy    <= signed'(27'({w_adx, 8'b0}));
                        r_cz    <= '0;
                        r_cnt   <= '0;
                        r_state <= S_CORD;
                    end
                end
                S_CORD: begin
                    r_cx  <= r_cx + w_ys;
                    r_cy  <= (r_cy > 0) ? r_cy - signed'(w_xs) : r_cy + signed'(w_xs);
                    r_cz  <= n_z;
                    r_cnt <= r_cnt + 5'd1;
                    if (r_cnt == 5'(CORDIC_STEPS - 1)) begin
                        r_ang   <= n_ang;
                        r_state <= S_AIM;
                    end
                end
                S_AIM: begin
                    r_m     <= {{5{w_aim[8]}}, w_aim, 4'b0} - {{2{r_pa[15]}}, r_pa};
                    r_final <= 1'b0;
                    r_state <= S_WRAP;
                end
                // wrap the error into a half turn either side
                S_WRAP: begin
                    if (r_m > HALF_TURN) begin
                        r_m <= r_m - FULL_TURN;
                    end else if (r_m <= -HALF_TURN) begin
                        r_m <= r_m + FULL_TURN;
                    end else if (!r_final) begin
                        if (!r_aim_done && !w_aligned) begin
                            r_ph    <= PH_AIM;
                            r_cv    <= 1'b0;
                            r_v     <= r_m;
                            r_state <= S_CDIV;
                        end else begin
                            r_aim_done <= 1'b1;
                            r_state    <= r_drive_done ? S_FIN : S_SQ1;
                        end
                    end else if (w_aligned) begin
                        r_res_l   <= '0;
                        r_res_r   <= '0;
                        r_res_arr <= 1'b1;
                        r_res_ph  <= PH_FINAL;
                        r_state   <= S_EMIT;
                    end else begin
                        r_ph    <= PH_FINAL;
                        r_cv    <= 1'b0;
                        r_v     <= r_m;
                        r_state <= S_CDIV;
                    end
                end
                S_FIN: begin
                    r_drive_done <= 1'b1;
                    r_m     <= {{4{r_hd[9]}}, r_hd, 4'b0} - {{2{r_pa[15]}}, r_pa};
                    r_final <= 1'b1;
                    r_state <= S_WRAP;
                end
                // distance check against the squared threshold
                S_SQ1: begin
                    r_s     <= w_prod;
                    r_state <= S_SQ2;
                end
                S_SQ2: begin
                    r_s     <= r_s + w_prod;
                    r_state <= S_SQ3;
                end
                S_SQ3: begin
                    if (r_s > {w_prod[25:0], 8'b0}) begin
                        r_src   <= r_s;
                        r_rem   <= '0;
                        r_root  <= '0;
                        r_cnt   <= '0;
                        r_state <= S_SQRT;
                    end else begin
                        r_state <= S_FIN;
                    end
                end
                S_SQRT: begin
                    r_rem  <= w_sq_ge ? 18'(w_remsh - 20'(w_trial)) : 18'(w_remsh);
                    r_root <= n_root;
                    r_src  <= {r_src[31:0], 2'b00};
                    r_cnt  <= r_cnt + 5'd1;
                    if (r_cnt == 5'd16) begin
                        r_ph    <= PH_DRIVE;
                        r_cv    <= 1'b1;
                        r_v     <= signed'({1'b0, n_root});
                        r_state <= S_CDIV;
                    end
                end
                // power curve: |v| / slowdown
                S_CDIV: begin
                    r_state <= S_CDWT;
                end
                S_CDWT: begin
                    if (w_div_done) begin
                        r_mag <= w_div_quo[16:0];
                        r_p   <= (w_e != 3'd1 && w_div_quo[16:0] > CURVE_CAP)
                                 ? CURVE_CAP : w_div_quo[16:0];
                        r_k   <= 3'd1;
                        r_state <= (w_e == 3'd1) ? S_CMIN : S_CPOW;
                    end
                end
                S_CPOW: begin
                    r_p <= (w_pn > 30'(CURVE_CAP)) ? CURVE_CAP : w_pn[16:0];
                    r_k <= r_k + 3'd1;
                    if (r_k + 3'd1 == w_e) begin
                        r_state <= S_CMIN;
                    end
                end
                // minimum term
                S_CMIN: begin
                    if (w_e == 3'd1) begin
                        r_num   <= w_prod[23:0];
                        r_state <= S_CMST;
                    end else begin
                        if (r_v > 0) begin
                            r_mterm <= signed'(25'({w_ma[6:0], 4'b0}));
                        end else if (r_v < 0) begin
                            r_mterm <= -signed'(25'({w_ma[6:0], 4'b0}));
                        end else begin
                            r_mterm <= '0;
                        end
                        r_state <= S_CGAIN;
                    end
                end
                S_CMST: begin
                    r_state <= S_CMWT;
                end
                S_CMWT: begin
                    if (w_div_done) begin
                        r_mterm <= r_v[17] ? -signed'(25'(w_div_quo))
                                           : signed'(25'(w_div_quo));
                        r_state <= S_CGAIN;
                    end
                end
                // gain term, clamp, then mix or finish
                S_CGAIN: begin
                    if (r_cv) begin
                        r_pd    <= w_pw;
                        r_cv    <= 1'b0;
                        r_v     <= r_m;
                        r_state <= S_CDIV;
                    end else begin
                        r_res_arr <= 1'b0;
                        r_res_ph  <= r_ph;
                        if (r_ph == PH_DRIVE) begin
                            r_res_l <= tz16(w_lsum);
                            r_res_r <= tz16(w_rsum);
                        end else begin
                            r_res_l <= tz16(14'(w_pw));
                            r_res_r <= -tz16(14'(w_pw));
                        end
                        r_state <= S_EMIT;
                    end
                end
                // hand the result to the output register once it is free
                S_EMIT: begin
                    if (!r_o_valid || !i_out_stall) begin
                        r_o_valid <= 1'b1;
                        r_o_l     <= r_res_l;
                        r_o_r     <= r_res_r;
                        r_o_arr   <= r_res_arr;
                        r_o_ph    <= r_res_ph;
                        r_state   <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_in_stall    = (r_state != S_IDLE);
    assign o_out_valid   = r_o_valid;
    assign o_left_power  = r_o_l;
    assign o_right_power = r_o_r;
    assign o_arrived     = r_o_arr;
    assign o_phase       = r_o_ph;

    // Arrival reports zero power in the final phase
    a_arrive_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_arrived |->
            o_left_power == 9'sd0 && o_right_power == 9'sd0 && o_phase == PH_FINAL)
        else $error("arrival with nonzero power");

    // Turn-in-place results spin the sides in opposite directions
    a_turn_mirror: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_phase != PH_DRIVE |-> o_right_power == -o_left_power)
        else $error("turn powers not mirrored");

    // Drive can only be finished once aim is finished
    a_flag_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_drive_done |-> r_aim_done)
        else $error("drive_done without aim_done");

    // Output register is never overwritten while a transfer is pending
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_EMIT && r_o_valid && i_out_stall |=> r_state == S_EMIT)
        else $error("result loaded over a pending transfer");

endmodule

// File: hdl/dtp_div.sv
`timescale 1ns / 1ps

// Restoring unsigned divider, one quotient bit per cycle.
// A zero divisor divides as one.
module dtp_div (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [dtp_pkg::DIV_NUM_W-1:0] i_num,
    input  logic [dtp_pkg::DIV_DEN_W-1:0] i_den,
    output logic                          o_done,
    output logic [dtp_pkg::DIV_NUM_W-1:0] o_quo
);
    import dtp_pkg::*;

    localparam int CNT_W = $clog2(DIV_NUM_W + 1);

    logic                 r_busy;
    logic                 r_done;
    logic [CNT_W-1:0]     r_cnt;
    logic [DIV_NUM_W-1:0] r_q;
    logic [DIV_DEN_W-1:0] r_rem;
    logic [DIV_DEN_W-1:0] r_den;

    logic [DIV_DEN_W:0] w_trial;
    logic               w_ge;

    // Shift in the next dividend bit and try a subtract
    assign w_trial = {r_rem, r_q[DIV_NUM_W-1]};
    assign w_ge    = w_trial >= {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(DIV_NUM_W);
                r_q    <= i_num;
                r_rem  <= '0;
                r_den  <= (i_den == '0) ? DIV_DEN_W'(1) : i_den;
            end else if (r_busy) begin
                r_rem <= w_ge ? DIV_DEN_W'(w_trial - {1'b0, r_den})
                              : DIV_DEN_W'(w_trial);
                r_q   <= {r_q[DIV_NUM_W-2:0], w_ge};
                r_cnt <= r_cnt - CNT_W'(1);
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_q;

endmodule
